// ===== design/tmwf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmwf_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the trimmed mean window filter.
// ----------------------------------------------------------------------------
package tmwf_pkg;

	localparam int WINDOW_LEN  = 7;
	localparam int SAMPLE_BITS = 16;

	localparam int IDX_W   = $clog2(WINDOW_LEN);
	// sum of the whole window, signed
	localparam int SUM_W   = SAMPLE_BITS + IDX_W;
	localparam int DIV     = WINDOW_LEN - 2;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

	// floor(2^SUM_W / DIV), estimate is low by at most one
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((longint'(1) << SUM_W) / DIV);
	localparam logic [SUM_W-1:0]   DIV_V    = SUM_W'(DIV);
	localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(WINDOW_LEN - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TRIM,
		ST_MUL,
		ST_FIX,
		ST_EMIT
	} tmwf_state_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic trim;
		logic mul;
		logic fix;
		logic emit;
	} tmwf_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} tmwf_sts_t;

endpackage

// ===== design/trimmed_mean_window_filter.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter
// Keeps the last seven signed samples and returns their mean with one
// minimum and one maximum removed, truncated toward zero.
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (lsb first)   notes
//  s_*      in   sample[15:0] signed        one item per sample
//  m_*      out  filtered[15:0] signed      one result item per input item
//
// an item goes from accept to result in these steps: accept, a read of
// each window entry in turn through the single window read port, trim,
// multiply, correction, load of the output register
// reset clears the window to zero and the oldest pointer at once
// a waiting result sits in the output register; the next item is accepted
// meanwhile and its result waits until the register is taken
module trimmed_mean_window_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [tmwf_pkg::DATA_W-1:0] s_tdata,  // sample
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tmwf_pkg::DATA_W-1:0] m_tdata   // filtered
);

	tmwf_pkg::tmwf_cmd_t                     cmd;
	tmwf_pkg::tmwf_sts_t                     sts;
	logic signed [tmwf_pkg::SAMPLE_BITS-1:0] filtered;

	tmwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tmwf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.sample   (s_tdata[tmwf_pkg::SAMPLE_BITS-1:0]),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.filtered (filtered)
	);

	assign m_tdata = tmwf_pkg::DATA_W'(unsigned'(filtered));

endmodule

// ===== design/tmwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmwf_ctrl
// Sequencer: takes an item, walks the window, trims, divides and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module tmwf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  tmwf_pkg::tmwf_sts_t sts,
	output tmwf_pkg::tmwf_cmd_t cmd
);

	tmwf_pkg::tmwf_state_t state_q;
	tmwf_pkg::tmwf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmwf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmwf_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = tmwf_pkg::ST_SCAN;
				end
			end
			tmwf_pkg::ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = tmwf_pkg::ST_TRIM;
				end
			end
			tmwf_pkg::ST_TRIM: state_d = tmwf_pkg::ST_MUL;
			tmwf_pkg::ST_MUL:  state_d = tmwf_pkg::ST_FIX;
			tmwf_pkg::ST_FIX:  state_d = tmwf_pkg::ST_EMIT;
			tmwf_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					state_d = tmwf_pkg::ST_IDLE;
				end
			end
			default: state_d = tmwf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			tmwf_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			tmwf_pkg::ST_SCAN: cmd.scan = 1'b1;
			tmwf_pkg::ST_TRIM: cmd.trim = 1'b1;
			tmwf_pkg::ST_MUL:  cmd.mul  = 1'b1;
			tmwf_pkg::ST_FIX:  cmd.fix  = 1'b1;
			tmwf_pkg::ST_EMIT: cmd.emit = sts.out_free;
			default: begin
				cmd      = '0;
				s_tready = 1'b0;
			end
		endcase
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded while output register still full");

	a_trim_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trim |-> $past(cmd.scan) && $past(sts.scan_last))
		else $error("trim step without a finished window scan");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.scan, cmd.trim, cmd.mul, cmd.fix, cmd.emit}))
		else $error("more than one datapath step at once");

endmodule

// ===== design/tmwf_dp.sv =====
// ----------------------------------------------------------------------------
// tmwf_dp
// Datapath: window registers, running sum with min and max, trimming,
// divide by window length minus two through a reciprocal multiply, and the
// output register.
// ----------------------------------------------------------------------------
module tmwf_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tmwf_pkg::tmwf_cmd_t                     cmd,
	output tmwf_pkg::tmwf_sts_t                     sts,
	input  logic signed [tmwf_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                    m_tready,
	output logic                                    m_tvalid,
	output logic signed [tmwf_pkg::SAMPLE_BITS-1:0] filtered
);

	logic signed [tmwf_pkg::SAMPLE_BITS-1:0] win_q [tmwf_pkg::WINDOW_LEN];
	logic [tmwf_pkg::IDX_W-1:0]              oldest_q;
	logic [tmwf_pkg::IDX_W-1:0]              idx_q;
	logic                                    out_valid_q;

	logic signed [tmwf_pkg::SUM_W-1:0]       sum_q;
	logic signed [tmwf_pkg::SAMPLE_BITS-1:0] lo_q;
	logic signed [tmwf_pkg::SAMPLE_BITS-1:0] hi_q;
	logic [tmwf_pkg::SUM_W-1:0]              abs_q;
	logic                                    neg_q;
	logic [tmwf_pkg::PROD_W-1:0]             prod_q;
	logic [tmwf_pkg::SUM_W-1:0]              qe_q;
	logic [tmwf_pkg::SUM_W-1:0]              rem_q;
	logic signed [tmwf_pkg::SAMPLE_BITS-1:0] out_q;

	logic signed [tmwf_pkg::SAMPLE_BITS-1:0] rd;
	logic signed [tmwf_pkg::SUM_W-1:0]       rd_ext;
	logic signed [tmwf_pkg::SUM_W-1:0]       trimmed;
	logic [tmwf_pkg::SUM_W-1:0]              qe;
	logic [tmwf_pkg::SUM_W-1:0]              quot;
	logic [tmwf_pkg::SUM_W-1:0]              res;

	assign rd      = win_q[idx_q];
	assign rd_ext  = tmwf_pkg::SUM_W'(rd);
	assign trimmed = sum_q - tmwf_pkg::SUM_W'(lo_q) - tmwf_pkg::SUM_W'(hi_q);
	assign qe      = prod_q[tmwf_pkg::SUM_W +: tmwf_pkg::SUM_W];
	assign quot    = qe_q + ((rem_q >= tmwf_pkg::DIV_V) ? tmwf_pkg::SUM_W'(1)
		: tmwf_pkg::SUM_W'(0));
	assign res     = neg_q ? (~quot + tmwf_pkg::SUM_W'(1)) : quot;

	// window, pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tmwf_pkg::WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
			oldest_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				win_q[oldest_q] <= sample;
				oldest_q        <= (oldest_q == tmwf_pkg::LAST_IDX) ? '0
					: oldest_q + tmwf_pkg::IDX_W'(1);
				idx_q           <= '0;
			end else if (cmd.scan && !sts.scan_last) begin
				// index stops on the last entry so the read stays in the window
				idx_q <= idx_q + tmwf_pkg::IDX_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// arithmetic payload
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (idx_q == '0) begin
				sum_q <= rd_ext;
				lo_q  <= rd;
				hi_q  <= rd;
			end else begin
				sum_q <= sum_q + rd_ext;
				if (rd < lo_q) begin
					lo_q <= rd;
				end
				if (rd > hi_q) begin
					hi_q <= rd;
				end
			end
		end
		if (cmd.trim) begin
			// divide the magnitude so the quotient truncates toward zero
			neg_q <= trimmed[tmwf_pkg::SUM_W-1];
			abs_q <= trimmed[tmwf_pkg::SUM_W-1] ? tmwf_pkg::SUM_W'(-trimmed)
				: tmwf_pkg::SUM_W'(trimmed);
		end
		if (cmd.mul) begin
			prod_q <= tmwf_pkg::PROD_W'(abs_q) * tmwf_pkg::PROD_W'(tmwf_pkg::RECIP);
		end
		if (cmd.fix) begin
			qe_q  <= qe;
			rem_q <= abs_q - tmwf_pkg::SUM_W'(qe * tmwf_pkg::DIV_V);
		end
		if (cmd.emit) begin
			out_q <= res[tmwf_pkg::SAMPLE_BITS-1:0];
		end
	end

	assign sts.scan_last = (idx_q == tmwf_pkg::LAST_IDX);
	assign sts.out_free  = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign filtered      = out_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fix |=> rem_q < (tmwf_pkg::DIV_V + tmwf_pkg::DIV_V))
		else $error("reciprocal estimate off by more than one");

	a_oldest_range: assert property (@(posedge clk) disable iff (!arst_n)
		oldest_q <= tmwf_pkg::LAST_IDX)
		else $error("oldest slot pointer out of window");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> idx_q == '0)
		else $error("window scan does not start at the first entry");

endmodule
